[rtl/core/hcbd_pkg.sv]
// Shared types, character codes and character-class helpers for the
// chunked body decoder. No dependencies.
package hcbd_pkg;

    // Framing mode, one-hot
    typedef enum logic [3:0] {
        MODE_SIZE  = 4'b0001,
        MODE_DATA  = 4'b0010,
        MODE_CRLF  = 4'b0100,
        MODE_TRAIL = 4'b1000
    } mode_t;

    // Chunk-size line parser phase, one-hot
    typedef enum logic [8:0] {
        PH_LWS    = 9'b0_0000_0001,
        PH_HEX    = 9'b0_0000_0010,
        PH_POSTWS = 9'b0_0000_0100,
        PH_EXTWS  = 9'b0_0000_1000,
        PH_NAME   = 9'b0_0001_0000,
        PH_EQ     = 9'b0_0010_0000,
        PH_TOKVAL = 9'b0_0100_0000,
        PH_QUOTED = 9'b0_1000_0000,
        PH_ESC    = 9'b1_0000_0000
    } phase_t;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_PROTO = 2'd1;
    localparam logic [1:0] ERR_SPACE = 2'd2;

    // Character codes
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    // Line terminators as seen in the recent-byte window
    localparam logic [15:0] CRLF_PAIR   = 16'h0D0A;
    localparam logic [31:0] CRLF_DOUBLE = 32'h0D0A0D0A;

    // One result transaction
    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic       body_done;
        logic       trailers_present;
        logic [1:0] error_code;
    } result_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SP) || (c == CH_TAB);
    endfunction

    function automatic logic is_tok(input logic [7:0] c);
        logic alnum;
        logic punct;
        alnum = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
                (c >= 8'h61 && c <= 8'h7A);
        punct = (c == 8'h21) || (c == 8'h23) || (c == 8'h24) || (c == 8'h25) ||
                (c == 8'h26) || (c == 8'h27) || (c == 8'h2A) || (c == 8'h2B) ||
                (c == 8'h2D) || (c == 8'h2E) || (c == 8'h5E) || (c == 8'h5F) ||
                (c == 8'h60) || (c == 8'h7C) || (c == 8'h7E);
        return alnum || punct;
    endfunction

    // Returns {valid, digit}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

[rtl/core/http_chunked_body_decoder.sv]
// HTTP/1.1 chunked body decoder: one input byte gives one result transaction.
// The accepted byte waits in the input stage, then moves to the result stage once
// that is free or being taken. Throughput: 1 byte per cycle while out_ready holds;
// the state update is one pass of logic in hcbd_core.
// Reset (rst_n, async, active low) empties both stages and returns the framing
// state to the start of a chunk-size line with no error. Depends on hcbd_pkg, hcbd_core.
module http_chunked_body_decoder #(
    parameter int LINE_BYTES = 4096
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] data_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       body_valid,
    output logic [7:0] body_byte,
    output logic       body_done,
    output logic       trailers_present,
    output logic [1:0] error_code
);

    logic               stage_valid_reg, stage_valid_next;
    logic [7:0]         stage_byte_reg;
    logic               out_valid_reg, out_valid_next;
    hcbd_pkg::result_t  result_reg;
    hcbd_pkg::result_t  step_result;
    logic               advance;
    logic               in_take;

    // Move the staged byte into the result register when it is free
    assign advance  = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !stage_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    assign stage_valid_next = in_take ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    hcbd_core #(
        .LINE_BYTES (LINE_BYTES)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (advance),
        .data_byte (stage_byte_reg),
        .result    (step_result)
    );

    // Hold control of both stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            stage_byte_reg <= data_byte;
        end
        if (advance) begin
            result_reg <= step_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign body_valid       = result_reg.body_valid;
    assign body_byte        = result_reg.body_byte;
    assign body_done        = result_reg.body_done;
    assign trailers_present = result_reg.trailers_present;
    assign error_code       = result_reg.error_code;

endmodule

[rtl/core/hcbd_core.sv]
// Framing state and single-byte update for the chunked body decoder.
// Depends on hcbd_pkg.
module hcbd_core #(
    parameter int LINE_BYTES = 4096
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step_en,
    input  logic [7:0]              data_byte,
    output hcbd_pkg::result_t       result
);

    localparam int LC_W = $clog2(LINE_BYTES + 1);
    localparam logic [LC_W-1:0] LINE_MAX = LC_W'(LINE_BYTES);
    localparam logic [LC_W-1:0] LC_ONE   = LC_W'(1);
    localparam logic [LC_W-1:0] LC_TWO   = LC_W'(2);
    localparam logic [LC_W-1:0] LC_FOUR  = LC_W'(4);

    hcbd_pkg::mode_t  mode_reg, mode_next;
    hcbd_pkg::phase_t phase_reg, phase_next;
    logic [63:0]      remaining_reg, remaining_next;
    logic [LC_W-1:0]  line_count_reg, line_count_next;
    logic [23:0]      recent_reg, recent_next;
    logic             line_bad_reg, line_bad_next;
    logic [1:0]       error_reg, error_next;

    logic [7:0]       prev;
    logic [31:0]      last4;
    logic [4:0]       hex;
    logic             digit_ovf;
    logic [63:0]      digit_acc;
    logic [63:0]      rem_dec;
    logic [LC_W-1:0]  lc_inc;
    logic             line_ok;
    logic             tok;
    logic             ws;
    logic             done;
    logic             trl;

    assign prev      = recent_reg[7:0];
    assign last4     = {recent_reg, data_byte};
    assign hex       = hcbd_pkg::hex_digit(data_byte);
    assign digit_ovf = remaining_reg[63:60] != 4'd0;
    assign digit_acc = {remaining_reg[59:0], hex[3:0]};
    assign rem_dec   = remaining_reg - 64'd1;
    assign lc_inc    = line_count_reg + LC_ONE;
    assign tok       = hcbd_pkg::is_tok(data_byte);
    assign ws        = hcbd_pkg::is_ws(data_byte);
    assign line_ok   = (phase_reg == hcbd_pkg::PH_HEX) || (phase_reg == hcbd_pkg::PH_POSTWS) ||
                       (phase_reg == hcbd_pkg::PH_NAME) || (phase_reg == hcbd_pkg::PH_TOKVAL);

    // Compute next state and the result for the byte in the input stage
    always_comb
    begin
        mode_next       = mode_reg;
        phase_next      = phase_reg;
        remaining_next  = remaining_reg;
        line_count_next = line_count_reg;
        recent_next     = recent_reg;
        line_bad_next   = line_bad_reg;
        error_next      = error_reg;
        done            = 1'b0;
        trl             = 1'b0;
        result          = '0;

        if (error_reg == hcbd_pkg::ERR_NONE) begin
            unique case (mode_reg)
                hcbd_pkg::MODE_SIZE:
                begin
                    if (line_count_reg >= LINE_MAX) begin
                        error_next = hcbd_pkg::ERR_SPACE;
                    end
                    else if (data_byte == hcbd_pkg::CH_LF && prev == hcbd_pkg::CH_CR) begin
                        line_count_next = lc_inc;
                        if (line_bad_reg || !line_ok) begin
                            error_next = hcbd_pkg::ERR_PROTO;
                        end
                        else begin
                            mode_next = (remaining_reg != 64'd0) ? hcbd_pkg::MODE_DATA
                                                                 : hcbd_pkg::MODE_TRAIL;
                            line_count_next = '0;
                            recent_next     = '0;
                            line_bad_next   = 1'b0;
                            phase_next      = hcbd_pkg::PH_LWS;
                        end
                    end
                    else begin
                        line_count_next = lc_inc;
                        recent_next     = last4[23:0];
                        // A CR not followed by LF spoils the line
                        if (prev == hcbd_pkg::CH_CR) begin
                            line_bad_next = 1'b1;
                        end
                        if (data_byte != hcbd_pkg::CH_CR) begin
                            unique case (phase_reg)
                                hcbd_pkg::PH_LWS:
                                begin
                                    if (!ws) begin
                                        if (!hex[4]) begin
                                            line_bad_next = 1'b1;
                                        end
                                        else begin
                                            if (digit_ovf) line_bad_next = 1'b1;
                                            else remaining_next = digit_acc;
                                            phase_next = hcbd_pkg::PH_HEX;
                                        end
                                    end
                                end
                                hcbd_pkg::PH_HEX:
                                begin
                                    if (hex[4]) begin
                                        if (digit_ovf) line_bad_next = 1'b1;
                                        else remaining_next = digit_acc;
                                    end
                                    else if (data_byte == hcbd_pkg::CH_SEMI) begin
                                        phase_next = hcbd_pkg::PH_EXTWS;
                                    end
                                    else if (ws) phase_next = hcbd_pkg::PH_POSTWS;
                                    else line_bad_next = 1'b1;
                                end
                                hcbd_pkg::PH_POSTWS:
                                begin
                                    if (data_byte == hcbd_pkg::CH_SEMI) begin
                                        phase_next = hcbd_pkg::PH_EXTWS;
                                    end
                                    else if (!ws) line_bad_next = 1'b1;
                                end
                                hcbd_pkg::PH_EXTWS:
                                begin
                                    if (tok) phase_next = hcbd_pkg::PH_NAME;
                                    else if (!ws) line_bad_next = 1'b1;
                                end
                                hcbd_pkg::PH_NAME, hcbd_pkg::PH_TOKVAL:
                                begin
                                    if (!tok) begin
                                        if (data_byte == hcbd_pkg::CH_EQ &&
                                            phase_reg == hcbd_pkg::PH_NAME) begin
                                            phase_next = hcbd_pkg::PH_EQ;
                                        end
                                        else if (ws) phase_next = hcbd_pkg::PH_POSTWS;
                                        else if (data_byte == hcbd_pkg::CH_SEMI) begin
                                            phase_next = hcbd_pkg::PH_EXTWS;
                                        end
                                        else line_bad_next = 1'b1;
                                    end
                                end
                                hcbd_pkg::PH_EQ:
                                begin
                                    if (data_byte == hcbd_pkg::CH_QUOTE) begin
                                        phase_next = hcbd_pkg::PH_QUOTED;
                                    end
                                    else if (tok) phase_next = hcbd_pkg::PH_TOKVAL;
                                    else line_bad_next = 1'b1;
                                end
                                hcbd_pkg::PH_QUOTED:
                                begin
                                    if (data_byte == hcbd_pkg::CH_QUOTE) begin
                                        phase_next = hcbd_pkg::PH_POSTWS;
                                    end
                                    else if (data_byte == hcbd_pkg::CH_BSL) begin
                                        phase_next = hcbd_pkg::PH_ESC;
                                    end
                                    else if ((data_byte < hcbd_pkg::CH_SP &&
                                              data_byte != hcbd_pkg::CH_TAB) ||
                                             data_byte == hcbd_pkg::CH_DEL) begin
                                        line_bad_next = 1'b1;
                                    end
                                end
                                hcbd_pkg::PH_ESC:
                                begin
                                    // Escaped control bytes are not allowed
                                    if (data_byte < hcbd_pkg::CH_SP ||
                                        data_byte == hcbd_pkg::CH_DEL) begin
                                        line_bad_next = 1'b1;
                                    end
                                    else phase_next = hcbd_pkg::PH_QUOTED;
                                end
                                default:
                                begin
                                    line_bad_next = 1'b1;
                                end
                            endcase
                        end
                    end
                end
                hcbd_pkg::MODE_DATA:
                begin
                    result.body_valid = 1'b1;
                    result.body_byte  = data_byte;
                    remaining_next    = rem_dec;
                    if (rem_dec == 64'd0) begin
                        mode_next       = hcbd_pkg::MODE_CRLF;
                        line_count_next = '0;
                    end
                end
                hcbd_pkg::MODE_CRLF:
                begin
                    if (data_byte != ((line_count_reg != '0) ? hcbd_pkg::CH_LF
                                                             : hcbd_pkg::CH_CR)) begin
                        error_next = hcbd_pkg::ERR_PROTO;
                    end
                    else if (lc_inc == LC_TWO) begin
                        mode_next       = hcbd_pkg::MODE_SIZE;
                        remaining_next  = '0;
                        line_count_next = '0;
                        recent_next     = '0;
                        line_bad_next   = 1'b0;
                        phase_next      = hcbd_pkg::PH_LWS;
                    end
                    else begin
                        line_count_next = lc_inc;
                    end
                end
                hcbd_pkg::MODE_TRAIL:
                begin
                    if (line_count_reg >= LINE_MAX) begin
                        error_next = hcbd_pkg::ERR_SPACE;
                    end
                    else begin
                        line_count_next = lc_inc;
                        recent_next     = last4[23:0];
                        if (lc_inc == LC_TWO && last4[15:0] == hcbd_pkg::CRLF_PAIR) begin
                            done = 1'b1;
                        end
                        else if (lc_inc >= LC_FOUR && last4 == hcbd_pkg::CRLF_DOUBLE) begin
                            done = 1'b1;
                            trl  = 1'b1;
                        end
                        // Body complete: back to a fresh size line
                        if (done) begin
                            mode_next       = hcbd_pkg::MODE_SIZE;
                            remaining_next  = '0;
                            line_count_next = '0;
                            recent_next     = '0;
                            line_bad_next   = 1'b0;
                            phase_next      = hcbd_pkg::PH_LWS;
                        end
                    end
                end
                default:
                begin
                    error_next = hcbd_pkg::ERR_PROTO;
                end
            endcase
        end

        // Drop everything but the code once an error is latched
        result.body_done        = done;
        result.trailers_present = trl;
        if (error_next != hcbd_pkg::ERR_NONE) begin
            result = '0;
        end
        result.error_code = error_next;
    end

    // Advance the state on each processed transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg       <= hcbd_pkg::MODE_SIZE;
            phase_reg      <= hcbd_pkg::PH_LWS;
            remaining_reg  <= '0;
            line_count_reg <= '0;
            recent_reg     <= '0;
            line_bad_reg   <= 1'b0;
            error_reg      <= hcbd_pkg::ERR_NONE;
        end
        else if (step_en) begin
            mode_reg       <= mode_next;
            phase_reg      <= phase_next;
            remaining_reg  <= remaining_next;
            line_count_reg <= line_count_next;
            recent_reg     <= recent_next;
            line_bad_reg   <= line_bad_next;
            error_reg      <= error_next;
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for http_chunked_body_decoder: streams chunked bodies
// byte by byte and checks every result transaction against a local predictor
// or a directed table entry. Depends on hcbd_pkg and the decoder RTL.
module testbench;

    localparam int LINE_LIMIT   = 4096;
    localparam int RANDOM_ITEMS = 850;
    localparam int DRAIN_CYCLES = 16;
    localparam int DIR_ROWS     = 21;
    localparam hcbd_pkg::result_t QUIET = '0;

    typedef struct packed {
        logic [7:0]        data;
        logic              typed;
        hcbd_pkg::result_t want;
    } stim_row_t;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       in_valid  = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic       out_valid;
    logic       body_valid;
    logic [7:0] body_byte;
    logic       body_done;
    logic       trailers_present;
    logic [1:0] error_code;

    // Predictor state, mirrors the decoder after reset
    hcbd_pkg::mode_t  framing     = hcbd_pkg::MODE_SIZE;
    hcbd_pkg::phase_t size_phase  = hcbd_pkg::PH_LWS;
    logic [63:0]      chunk_left  = '0;
    int               line_cnt    = 0;
    logic [23:0]      tail_bytes  = '0;
    logic             line_broken = 1'b0;
    logic [1:0]       held_error  = hcbd_pkg::ERR_NONE;

    hcbd_pkg::result_t awaited_results [$];
    logic [7:0]        line_bytes [$];
    int                src_idle_pct   = 0;
    int                sink_stall_pct = 0;
    int                items_sent     = 0;
    int                fail_count     = 0;
    hcbd_pkg::result_t got_res;
    hcbd_pkg::result_t want_res;

    // Directed body: one extension with an escaped quoted value, two data bytes
    // at the byte extremes, then a zero chunk with no trailers.
    stim_row_t directed [DIR_ROWS] = '{
        {hcbd_pkg::CH_SP,    1'b1, QUIET},
        {"2",                1'b0, QUIET},
        {hcbd_pkg::CH_SEMI,  1'b0, QUIET},
        {"a",                1'b0, QUIET},
        {hcbd_pkg::CH_EQ,    1'b0, QUIET},
        {hcbd_pkg::CH_QUOTE, 1'b0, QUIET},
        {hcbd_pkg::CH_BSL,   1'b0, QUIET},
        {8'hFF,              1'b0, QUIET},
        {hcbd_pkg::CH_QUOTE, 1'b0, QUIET},
        {hcbd_pkg::CH_CR,    1'b0, QUIET},
        {hcbd_pkg::CH_LF,    1'b0, QUIET},
        {8'h00,              1'b1, {1'b1, 8'h00, 1'b0, 1'b0, hcbd_pkg::ERR_NONE}},
        {8'hFF,              1'b1, {1'b1, 8'hFF, 1'b0, 1'b0, hcbd_pkg::ERR_NONE}},
        {hcbd_pkg::CH_CR,    1'b0, QUIET},
        {hcbd_pkg::CH_LF,    1'b0, QUIET},
        {"0",                1'b0, QUIET},
        {hcbd_pkg::CH_TAB,   1'b0, QUIET},
        {hcbd_pkg::CH_CR,    1'b0, QUIET},
        {hcbd_pkg::CH_LF,    1'b0, QUIET},
        {hcbd_pkg::CH_CR,    1'b0, QUIET},
        {hcbd_pkg::CH_LF,    1'b1, {1'b0, 8'h00, 1'b1, 1'b0, hcbd_pkg::ERR_NONE}}
    };

    http_chunked_body_decoder #(
        .LINE_BYTES(LINE_LIMIT)
    ) uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .data_byte        (data_byte),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .body_valid       (body_valid),
        .body_byte        (body_byte),
        .body_done        (body_done),
        .trailers_present (trailers_present),
        .error_code       (error_code)
    );

    always #4 clk = ~clk;

    // ---------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------
    function automatic bit blank(input logic [7:0] c);
        return (c == hcbd_pkg::CH_SP) || (c == hcbd_pkg::CH_TAB);
    endfunction

    function automatic bit tchar(input logic [7:0] c);
        if ((c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z"))
        begin
            return 1'b1;
        end
        case (c)
            "!", "#", "$", "%", "&", "'", "*", "+", "-", ".", "^", "_", "|", "~":
                return 1'b1;
            8'h60:   return 1'b1;  // grave accent
            default: return 1'b0;
        endcase
    endfunction

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // ---------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------
    function automatic void start_line();
        line_cnt    = 0;
        tail_bytes  = '0;
        line_broken = 1'b0;
        size_phase  = hcbd_pkg::PH_LWS;
    endfunction

    // Accumulate one size digit; flag the line once the size no longer fits
    function automatic void shift_in_digit(input int d);
        if (chunk_left[63:60] != 4'h0) line_broken = 1'b1;
        else chunk_left = {chunk_left[59:0], d[3:0]};
    endfunction

    // Advance the size-line parser over one content byte
    function automatic void take_size_char(input logic [7:0] c);
        int d;
        d = hex_value(c);
        case (size_phase)
            hcbd_pkg::PH_LWS:
                if (!blank(c))
                begin
                    if (d < 0) line_broken = 1'b1;
                    else
                    begin
                        shift_in_digit(d);
                        size_phase = hcbd_pkg::PH_HEX;
                    end
                end
            hcbd_pkg::PH_HEX:
                if (d >= 0) shift_in_digit(d);
                else if (c == hcbd_pkg::CH_SEMI) size_phase = hcbd_pkg::PH_EXTWS;
                else if (blank(c)) size_phase = hcbd_pkg::PH_POSTWS;
                else line_broken = 1'b1;
            hcbd_pkg::PH_POSTWS:
                if (c == hcbd_pkg::CH_SEMI) size_phase = hcbd_pkg::PH_EXTWS;
                else if (!blank(c)) line_broken = 1'b1;
            hcbd_pkg::PH_EXTWS:
                if (tchar(c)) size_phase = hcbd_pkg::PH_NAME;
                else if (!blank(c)) line_broken = 1'b1;
            hcbd_pkg::PH_NAME, hcbd_pkg::PH_TOKVAL:
                if (!tchar(c))
                begin
                    if (c == hcbd_pkg::CH_EQ && size_phase == hcbd_pkg::PH_NAME)
                        size_phase = hcbd_pkg::PH_EQ;
                    else if (blank(c)) size_phase = hcbd_pkg::PH_POSTWS;
                    else if (c == hcbd_pkg::CH_SEMI) size_phase = hcbd_pkg::PH_EXTWS;
                    else line_broken = 1'b1;
                end
            hcbd_pkg::PH_EQ:
                if (c == hcbd_pkg::CH_QUOTE) size_phase = hcbd_pkg::PH_QUOTED;
                else if (tchar(c)) size_phase = hcbd_pkg::PH_TOKVAL;
                else line_broken = 1'b1;
            hcbd_pkg::PH_QUOTED:
                if (c == hcbd_pkg::CH_QUOTE) size_phase = hcbd_pkg::PH_POSTWS;
                else if (c == hcbd_pkg::CH_BSL) size_phase = hcbd_pkg::PH_ESC;
                else if ((c < 8'h20 && c != hcbd_pkg::CH_TAB) || c == hcbd_pkg::CH_DEL)
                    line_broken = 1'b1;
            hcbd_pkg::PH_ESC:
                if (c < 8'h20 || c == hcbd_pkg::CH_DEL) line_broken = 1'b1;
                else size_phase = hcbd_pkg::PH_QUOTED;
            default:
                line_broken = 1'b1;
        endcase
    endfunction

    // Work out the result transaction for one body byte and advance the state
    function automatic hcbd_pkg::result_t decode_byte(input logic [7:0] b);
        hcbd_pkg::result_t r;
        logic [7:0]        prev;
        logic [31:0]       win;
        logic              ok;
        r    = '0;
        prev = tail_bytes[7:0];
        win  = {tail_bytes, b};
        if (held_error == hcbd_pkg::ERR_NONE)
        begin
            case (framing)
                hcbd_pkg::MODE_SIZE:
                    if (line_cnt >= LINE_LIMIT) held_error = hcbd_pkg::ERR_SPACE;
                    else
                    begin
                        line_cnt++;
                        if (b == hcbd_pkg::CH_LF && prev == hcbd_pkg::CH_CR)
                        begin
                            ok = (size_phase == hcbd_pkg::PH_HEX) ||
                                 (size_phase == hcbd_pkg::PH_POSTWS) ||
                                 (size_phase == hcbd_pkg::PH_NAME) ||
                                 (size_phase == hcbd_pkg::PH_TOKVAL);
                            if (line_broken || !ok) held_error = hcbd_pkg::ERR_PROTO;
                            else
                            begin
                                if (chunk_left != 64'd0) framing = hcbd_pkg::MODE_DATA;
                                else framing = hcbd_pkg::MODE_TRAIL;
                                start_line();
                            end
                        end
                        else
                        begin
                            if (prev == hcbd_pkg::CH_CR) line_broken = 1'b1;
                            if (b != hcbd_pkg::CH_CR) take_size_char(b);
                            tail_bytes = win[23:0];
                        end
                    end
                hcbd_pkg::MODE_DATA:
                begin
                    r.body_valid = 1'b1;
                    r.body_byte  = b;
                    chunk_left--;
                    if (chunk_left == 64'd0)
                    begin
                        framing  = hcbd_pkg::MODE_CRLF;
                        line_cnt = 0;
                    end
                end
                hcbd_pkg::MODE_CRLF:
                    if (b != ((line_cnt != 0) ? hcbd_pkg::CH_LF : hcbd_pkg::CH_CR))
                        held_error = hcbd_pkg::ERR_PROTO;
                    else
                    begin
                        line_cnt++;
                        if (line_cnt == 2)
                        begin
                            framing    = hcbd_pkg::MODE_SIZE;
                            chunk_left = '0;
                            start_line();
                        end
                    end
                hcbd_pkg::MODE_TRAIL:
                    if (line_cnt >= LINE_LIMIT) held_error = hcbd_pkg::ERR_SPACE;
                    else
                    begin
                        line_cnt++;
                        if (line_cnt == 2 && win[15:0] == hcbd_pkg::CRLF_PAIR)
                        begin
                            r.body_done = 1'b1;
                        end
                        else if (line_cnt >= 4 && win == hcbd_pkg::CRLF_DOUBLE)
                        begin
                            r.body_done        = 1'b1;
                            r.trailers_present = 1'b1;
                        end
                        tail_bytes = win[23:0];
                        if (r.body_done)
                        begin
                            framing    = hcbd_pkg::MODE_SIZE;
                            chunk_left = '0;
                            start_line();
                        end
                    end
                default:
                    held_error = hcbd_pkg::ERR_PROTO;
            endcase
        end
        if (held_error != hcbd_pkg::ERR_NONE) r = '0;
        r.error_code = held_error;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic typed,
                             input hcbd_pkg::result_t want);
        hcbd_pkg::result_t model_res;
        model_res = decode_byte(b);
        // insert idle cycles before the transaction
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        awaited_results.push_back(typed ? want : model_res);
        items_sent++;
    endtask

    task automatic put(input logic [7:0] b);
        send_byte(b, 1'b0, QUIET);
    endtask

    task automatic send_line();
        foreach (line_bytes[i]) put(line_bytes[i]);
    endtask

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? hcbd_pkg::CH_SP : hcbd_pkg::CH_TAB;
    endfunction

    function automatic logic [7:0] rand_tok();
        logic [7:0] c;
        do c = 8'($urandom_range(33, 126)); while (!tchar(c));
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    // ---------------------------------------------------------------
    // Well-formed stimulus with random content
    // ---------------------------------------------------------------
    // Build and send one chunk-size line
    task automatic emit_size_line(input logic [63:0] size);
        int         ndig;
        int         sel;
        logic [7:0] c;
        line_bytes.delete();
        repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 3) : 0)
            line_bytes.push_back(rand_blank());
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(1, 20) : 0)
            line_bytes.push_back("0");
        ndig = 1;
        for (int i = 1; i < 16; i++)
        begin
            if ((size >> (4 * i)) != 64'd0) ndig = i + 1;
        end
        for (int i = ndig - 1; i >= 0; i--)
            line_bytes.push_back(hex_char(int'((size >> (4 * i)) & 64'hF)));
        repeat ($urandom_range(0, 1)) line_bytes.push_back(rand_blank());
        // extensions: name, then an optional token or quoted value
        repeat ($urandom_range(0, 1) ? 0 : $urandom_range(1, 3))
        begin
            line_bytes.push_back(hcbd_pkg::CH_SEMI);
            repeat ($urandom_range(0, 1)) line_bytes.push_back(rand_blank());
            repeat ($urandom_range(1, 6)) line_bytes.push_back(rand_tok());
            sel = $urandom_range(0, 2);
            if (sel != 0)
            begin
                line_bytes.push_back(hcbd_pkg::CH_EQ);
                if (sel == 1)
                begin
                    repeat ($urandom_range(1, 6)) line_bytes.push_back(rand_tok());
                end
                else
                begin
                    line_bytes.push_back(hcbd_pkg::CH_QUOTE);
                    repeat ($urandom_range(0, 8))
                    begin
                        if ($urandom_range(0, 4) == 0)
                        begin
                            line_bytes.push_back(hcbd_pkg::CH_BSL);
                            do c = 8'($urandom_range(32, 255));
                            while (c == hcbd_pkg::CH_DEL);
                        end
                        else
                        begin
                            do c = 8'($urandom_range(0, 255));
                            while (!((c >= 8'h20 && c != hcbd_pkg::CH_DEL &&
                                      c != hcbd_pkg::CH_QUOTE && c != hcbd_pkg::CH_BSL) ||
                                     c == hcbd_pkg::CH_TAB));
                        end
                        line_bytes.push_back(c);
                    end
                    line_bytes.push_back(hcbd_pkg::CH_QUOTE);
                end
            end
            repeat ($urandom_range(0, 1)) line_bytes.push_back(rand_blank());
        end
        line_bytes.push_back(hcbd_pkg::CH_CR);
        line_bytes.push_back(hcbd_pkg::CH_LF);
        send_line();
    endtask

    // Build and send a trailer section
    task automatic emit_trailers();
        int         n_lines;
        logic [7:0] c;
        line_bytes.delete();
        n_lines = $urandom_range(0, 1) ? 0 : $urandom_range(1, 3);
        repeat (n_lines)
        begin
            repeat ($urandom_range(1, 12))
            begin
                c = 8'($urandom_range(0, 255));
                line_bytes.push_back(c);
                // keep a stray CR from pairing with an LF
                if (c == hcbd_pkg::CH_CR) line_bytes.push_back("x");
            end
            line_bytes.push_back(hcbd_pkg::CH_CR);
            line_bytes.push_back(hcbd_pkg::CH_LF);
        end
        line_bytes.push_back(hcbd_pkg::CH_CR);
        line_bytes.push_back(hcbd_pkg::CH_LF);
        send_line();
    endtask

    task automatic emit_body();
        int          pick;
        logic [63:0] size;
        repeat ($urandom_range(0, 3))
        begin
            pick = $urandom_range(0, 19);
            size = 64'((pick < 14) ? $urandom_range(1, 8) :
                       (pick < 19) ? $urandom_range(9, 40) : $urandom_range(41, 120));
            emit_size_line(size);
            repeat (size) put(8'($urandom_range(0, 255)));
            put(hcbd_pkg::CH_CR);
            put(hcbd_pkg::CH_LF);
        end
        emit_size_line(64'd0);
        emit_trailers();
    endtask

    // ---------------------------------------------------------------
    // One fault; errors hold until reset, so this closes the run
    // ---------------------------------------------------------------
    task automatic emit_fault();
        int         sel;
        logic [7:0] c;
        case ($urandom_range(0, 5))
            0:
            begin
                // bad chunk terminator
                emit_size_line(64'd1);
                put(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1))
                begin
                    do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_CR);
                    put(c);
                end
                else
                begin
                    put(hcbd_pkg::CH_CR);
                    do c = 8'($urandom_range(0, 255)); while (c == hcbd_pkg::CH_LF);
                    put(c);
                end
            end
            1:
            begin
                // bare CR or LF inside a size line
                put(hex_char($urandom_range(1, 15)));
                if ($urandom_range(0, 1))
                begin
                    put(hcbd_pkg::CH_CR);
                    put("x");
                end
                else
                begin
                    put(hcbd_pkg::CH_LF);
                end
                put(hcbd_pkg::CH_CR);
                put(hcbd_pkg::CH_LF);
            end
            2:
            begin
                // size wider than 64 bits
                put(hex_char($urandom_range(1, 15)));
                repeat (16) put(hex_char($urandom_range(0, 15)));
                put(hcbd_pkg::CH_CR);
                put(hcbd_pkg::CH_LF);
            end
            3:
            begin
                // escaped control byte in a quoted value
                put("1");
                put(hcbd_pkg::CH_SEMI);
                put("e");
                put(hcbd_pkg::CH_EQ);
                put(hcbd_pkg::CH_QUOTE);
                put(hcbd_pkg::CH_BSL);
                c = 8'($urandom_range(0, 32));
                put((c == 8'd32) ? hcbd_pkg::CH_DEL : c);
                put(hcbd_pkg::CH_QUOTE);
                put(hcbd_pkg::CH_CR);
                put(hcbd_pkg::CH_LF);
            end
            4:
            begin
                // line that ends before it is complete
                sel = $urandom_range(0, 2);
                if (sel != 0)
                begin
                    put("1");
                    put(hcbd_pkg::CH_SEMI);
                    if (sel == 2)
                    begin
                        put("a");
                        put(hcbd_pkg::CH_EQ);
                    end
                end
                put(hcbd_pkg::CH_CR);
                put(hcbd_pkg::CH_LF);
            end
            default:
                repeat (64) put(8'($urandom_range(0, 255)));
        endcase
        // the error code must hold on every later byte
        repeat (16) put(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Result checker and output backpressure
    // ---------------------------------------------------------------
    task automatic log_failure(input string what);
        fail_count++;
        if (fail_count <= 10) $display("ERROR at %0t: %s", $realtime, what);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            got_res = {body_valid, body_byte, body_done, trailers_present, error_code};
            if (awaited_results.size() == 0)
            begin
                log_failure($sformatf("result transaction with nothing pending: %h", got_res));
            end
            else
            begin
                want_res = awaited_results.pop_front();
                if (got_res.body_valid !== want_res.body_valid ||
                    got_res.body_byte !== want_res.body_byte ||
                    got_res.body_done !== want_res.body_done ||
                    got_res.trailers_present !== want_res.trailers_present ||
                    got_res.error_code !== want_res.error_code)
                begin
                    log_failure($sformatf({"expected valid=%0b byte=%02h done=%0b trl=%0b ",
                        "err=%0d, got valid=%0b byte=%02h done=%0b trl=%0b err=%0d"},
                        want_res.body_valid, want_res.body_byte, want_res.body_done,
                        want_res.trailers_present, want_res.error_code,
                        got_res.body_valid, got_res.body_byte, got_res.body_done,
                        got_res.trailers_present, got_res.error_code));
                end
            end
        end
        out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        int body_n;
        int stop_at;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // walk the directed table
        foreach (directed[i]) send_byte(directed[i].data, directed[i].typed, directed[i].want);

        // random bodies, rotating through the idle and stall phases
        stop_at = items_sent + RANDOM_ITEMS;
        body_n  = 0;
        while (items_sent < stop_at)
        begin
            case ((body_n / 2) % 4)
                0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1:       begin src_idle_pct = 50; sink_stall_pct = 0;  end
                2:       begin src_idle_pct = 0;  sink_stall_pct = 50; end
                default: begin src_idle_pct = 31; sink_stall_pct = 31; end
            endcase
            emit_body();
            body_n++;
        end

        emit_fault();
        in_valid <= 1'b0;

        // drain outstanding results, then allow for stray ones
        while (awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_results.size() != 0) log_failure("results still pending at end of run");

        if (fail_count == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #(5_000_000);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
